/* hdl/imuni_pkg.sv */
// ----------------------------------------------------------------------------
// imuni_pkg: shared types, constants and microcode for the IMU integrator
// Payload structs, register codes, sequencer state and the step table that
// drives the shared multiply-accumulate datapath.
// ----------------------------------------------------------------------------
package imuni_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned OP_W      = 33;
  localparam int unsigned PROD_W    = 2 * OP_W;
  localparam int unsigned ACC_W     = 52;
  localparam int unsigned S_W       = 50;
  localparam int unsigned PP_W      = 34;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned NUM_STEPS = 48;
  localparam int unsigned STEP_W    = 6;

  localparam logic [STEP_W-1:0]        LAST_STEP     = STEP_W'(NUM_STEPS - 1);
  localparam logic [DATA_W-1:0]        STEP_TIME_RST = 32'd4294967;
  localparam logic signed [DATA_W-1:0] GRAVITY_RST   = -32'sd642908;
  localparam logic signed [DATA_W-1:0] QUAT_ONE      = 32'sh4000_0000;
  localparam logic signed [63:0]       ONE_Q30       = 64'sd1073741824;

  typedef struct packed {
    logic signed [DATA_W-1:0] gyro_x;
    logic signed [DATA_W-1:0] gyro_y;
    logic signed [DATA_W-1:0] gyro_z;
    logic signed [DATA_W-1:0] accel_x;
    logic signed [DATA_W-1:0] accel_y;
    logic signed [DATA_W-1:0] accel_z;
  } imu_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] quat_w;
    logic signed [DATA_W-1:0] quat_x;
    logic signed [DATA_W-1:0] quat_y;
    logic signed [DATA_W-1:0] quat_z;
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] pos_z;
    logic signed [DATA_W-1:0] vel_x;
    logic signed [DATA_W-1:0] vel_y;
    logic signed [DATA_W-1:0] vel_z;
  } imu_out_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_TIME    = 4'd0,
    REG_GRAVITY_Z    = 4'd1,
    REG_GYRO_BIAS_X  = 4'd2,
    REG_GYRO_BIAS_Y  = 4'd3,
    REG_GYRO_BIAS_Z  = 4'd4,
    REG_ACCEL_BIAS_X = 4'd5,
    REG_ACCEL_BIAS_Y = 4'd6,
    REG_ACCEL_BIAS_Z = 4'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_ACC, ST_OUT} seq_state_e;

  typedef enum logic [3:0] {
    SRC_W, SRC_A, SRC_Q, SRC_R, SRC_DT, SRC_DT2, SRC_SLO, SRC_SHI, SRC_V, SRC_F
  } src_e;

  typedef enum logic [2:0] {SH_0, SH_16, SH_30, SH_32, SH_33} shift_e;

  typedef enum logic [1:0] {INIT_ZERO, INIT_GRAV, INIT_POS, INIT_VEL} init_e;

  typedef enum logic [2:0] {
    WR_NONE, WR_S, WR_PP, WR_F, WR_DT2, WR_QUAT, WR_POS, WR_VEL
  } wr_e;

  typedef struct packed {
    src_e        a_src;
    logic [3:0]  a_idx;
    logic        a_neg;
    src_e        b_src;
    logic [3:0]  b_idx;
    shift_e      shift;
    logic        first;
    init_e       init;
    wr_e         wr;
    logic [3:0]  idx;
  } uop_t;

  typedef struct packed {
    logic              load;
    logic              mul_en;
    logic              acc_en;
    logic [STEP_W-1:0] step;
  } seq_ctrl_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (x < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return x[DATA_W-1:0];
  endfunction

  function automatic uop_t mk(input src_e as, input int ai, input logic neg,
                              input src_e bs, input int bi, input shift_e sh,
                              input logic first, input init_e init,
                              input wr_e wr, input int idx);
    uop_t u;
    u.a_src = as;
    u.a_idx = 4'(ai);
    u.a_neg = neg;
    u.b_src = bs;
    u.b_idx = 4'(bi);
    u.shift = sh;
    u.first = first;
    u.init  = init;
    u.wr    = wr;
    u.idx   = 4'(idx);
    return u;
  endfunction

  // quaternion rate sums, quaternion products, rotated force, dt^2,
  // quaternion update (low then high half of s), then position and velocity
  function automatic uop_t ucode(input logic [STEP_W-1:0] k);
    uop_t u;
    unique case (k)
      6'd0:  u = mk(SRC_W, 0, 1'b1, SRC_Q, 1, SH_16, 1'b1, INIT_ZERO, WR_NONE, 0);
      6'd1:  u = mk(SRC_W, 1, 1'b1, SRC_Q, 2, SH_16, 1'b0, INIT_ZERO, WR_NONE, 0);
      6'd2:  u = mk(SRC_W, 2, 1'b1, SRC_Q, 3, SH_16, 1'b0, INIT_ZERO, WR_S,    0);
      6'd3:  u = mk(SRC_W, 0, 1'b0, SRC_Q, 0, SH_16, 1'b1, INIT_ZERO, WR_NONE, 1);
      6'd4:  u = mk(SRC_W, 2, 1'b0, SRC_Q, 2, SH_16, 1'b0, INIT_ZERO, WR_NONE, 1);
      6'd5:  u = mk(SRC_W, 1, 1'b1, SRC_Q, 3, SH_16, 1'b0, INIT_ZERO, WR_S,    1);
      6'd6:  u = mk(SRC_W, 1, 1'b0, SRC_Q, 0, SH_16, 1'b1, INIT_ZERO, WR_NONE, 2);
      6'd7:  u = mk(SRC_W, 2, 1'b1, SRC_Q, 1, SH_16, 1'b0, INIT_ZERO, WR_NONE, 2);
      6'd8:  u = mk(SRC_W, 0, 1'b0, SRC_Q, 3, SH_16, 1'b0, INIT_ZERO, WR_S,    2);
      6'd9:  u = mk(SRC_W, 2, 1'b0, SRC_Q, 0, SH_16, 1'b1, INIT_ZERO, WR_NONE, 3);
      6'd10: u = mk(SRC_W, 1, 1'b0, SRC_Q, 1, SH_16, 1'b0, INIT_ZERO, WR_NONE, 3);
      6'd11: u = mk(SRC_W, 0, 1'b1, SRC_Q, 2, SH_16, 1'b0, INIT_ZERO, WR_S,    3);
      6'd12: u = mk(SRC_Q, 1, 1'b0, SRC_Q, 1, SH_30, 1'b1, INIT_ZERO, WR_PP,   0);
      6'd13: u = mk(SRC_Q, 2, 1'b0, SRC_Q, 2, SH_30, 1'b1, INIT_ZERO, WR_PP,   1);
      6'd14: u = mk(SRC_Q, 3, 1'b0, SRC_Q, 3, SH_30, 1'b1, INIT_ZERO, WR_PP,   2);
      6'd15: u = mk(SRC_Q, 1, 1'b0, SRC_Q, 2, SH_30, 1'b1, INIT_ZERO, WR_PP,   3);
      6'd16: u = mk(SRC_Q, 1, 1'b0, SRC_Q, 3, SH_30, 1'b1, INIT_ZERO, WR_PP,   4);
      6'd17: u = mk(SRC_Q, 2, 1'b0, SRC_Q, 3, SH_30, 1'b1, INIT_ZERO, WR_PP,   5);
      6'd18: u = mk(SRC_Q, 0, 1'b0, SRC_Q, 1, SH_30, 1'b1, INIT_ZERO, WR_PP,   6);
      6'd19: u = mk(SRC_Q, 0, 1'b0, SRC_Q, 2, SH_30, 1'b1, INIT_ZERO, WR_PP,   7);
      6'd20: u = mk(SRC_Q, 0, 1'b0, SRC_Q, 3, SH_30, 1'b1, INIT_ZERO, WR_PP,   8);
      6'd21: u = mk(SRC_R, 0, 1'b0, SRC_A, 0, SH_30, 1'b1, INIT_ZERO, WR_NONE, 0);
      6'd22: u = mk(SRC_R, 1, 1'b0, SRC_A, 1, SH_30, 1'b0, INIT_ZERO, WR_NONE, 0);
      6'd23: u = mk(SRC_R, 2, 1'b0, SRC_A, 2, SH_30, 1'b0, INIT_ZERO, WR_F,    0);
      6'd24: u = mk(SRC_R, 3, 1'b0, SRC_A, 0, SH_30, 1'b1, INIT_ZERO, WR_NONE, 1);
      6'd25: u = mk(SRC_R, 4, 1'b0, SRC_A, 1, SH_30, 1'b0, INIT_ZERO, WR_NONE, 1);
      6'd26: u = mk(SRC_R, 5, 1'b0, SRC_A, 2, SH_30, 1'b0, INIT_ZERO, WR_F,    1);
      6'd27: u = mk(SRC_R, 6, 1'b0, SRC_A, 0, SH_30, 1'b1, INIT_GRAV, WR_NONE, 2);
      6'd28: u = mk(SRC_R, 7, 1'b0, SRC_A, 1, SH_30, 1'b0, INIT_ZERO, WR_NONE, 2);
      6'd29: u = mk(SRC_R, 8, 1'b0, SRC_A, 2, SH_30, 1'b0, INIT_ZERO, WR_F,    2);
      6'd30: u = mk(SRC_DT, 0, 1'b0, SRC_DT, 0, SH_32, 1'b1, INIT_ZERO, WR_DT2, 0);
      6'd31: u = mk(SRC_SLO, 0, 1'b0, SRC_DT, 0, SH_32, 1'b1, INIT_ZERO, WR_NONE, 0);
      6'd32: u = mk(SRC_SHI, 0, 1'b0, SRC_DT, 0, SH_0,  1'b0, INIT_ZERO, WR_QUAT, 0);
      6'd33: u = mk(SRC_SLO, 1, 1'b0, SRC_DT, 0, SH_32, 1'b1, INIT_ZERO, WR_NONE, 1);
      6'd34: u = mk(SRC_SHI, 1, 1'b0, SRC_DT, 0, SH_0,  1'b0, INIT_ZERO, WR_QUAT, 1);
      6'd35: u = mk(SRC_SLO, 2, 1'b0, SRC_DT, 0, SH_32, 1'b1, INIT_ZERO, WR_NONE, 2);
      6'd36: u = mk(SRC_SHI, 2, 1'b0, SRC_DT, 0, SH_0,  1'b0, INIT_ZERO, WR_QUAT, 2);
      6'd37: u = mk(SRC_SLO, 3, 1'b0, SRC_DT, 0, SH_32, 1'b1, INIT_ZERO, WR_NONE, 3);
      6'd38: u = mk(SRC_SHI, 3, 1'b0, SRC_DT, 0, SH_0,  1'b0, INIT_ZERO, WR_QUAT, 3);
      6'd39: u = mk(SRC_V, 0, 1'b0, SRC_DT,  0, SH_32, 1'b1, INIT_POS, WR_NONE, 0);
      6'd40: u = mk(SRC_F, 0, 1'b0, SRC_DT2, 0, SH_33, 1'b0, INIT_POS, WR_POS,  0);
      6'd41: u = mk(SRC_F, 0, 1'b0, SRC_DT,  0, SH_32, 1'b1, INIT_VEL, WR_VEL,  0);
      6'd42: u = mk(SRC_V, 1, 1'b0, SRC_DT,  0, SH_32, 1'b1, INIT_POS, WR_NONE, 1);
      6'd43: u = mk(SRC_F, 1, 1'b0, SRC_DT2, 0, SH_33, 1'b0, INIT_POS, WR_POS,  1);
      6'd44: u = mk(SRC_F, 1, 1'b0, SRC_DT,  0, SH_32, 1'b1, INIT_VEL, WR_VEL,  1);
      6'd45: u = mk(SRC_V, 2, 1'b0, SRC_DT,  0, SH_32, 1'b1, INIT_POS, WR_NONE, 2);
      6'd46: u = mk(SRC_F, 2, 1'b0, SRC_DT2, 0, SH_33, 1'b0, INIT_POS, WR_POS,  2);
      6'd47: u = mk(SRC_F, 2, 1'b0, SRC_DT,  0, SH_32, 1'b1, INIT_VEL, WR_VEL,  2);
      default: u = mk(SRC_DT, 0, 1'b0, SRC_DT, 0, SH_0, 1'b0, INIT_ZERO, WR_NONE, 0);
    endcase
    return u;
  endfunction

endpackage

/* hdl/imuni_seq.sv */
// ----------------------------------------------------------------------------
// imuni_seq: step sequencer for the integrator
// Takes a request, walks the step table in multiply / accumulate pairs and
// holds the result until it is taken.
// ----------------------------------------------------------------------------
module imuni_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output imuni_pkg::seq_ctrl_t ctrl_o
);
  import imuni_pkg::*;

  seq_state_e        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    step_d        = step_q;
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    ctrl_o.load   = 1'b0;
    ctrl_o.mul_en = 1'b0;
    ctrl_o.acc_en = 1'b0;
    ctrl_o.step   = step_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          step_d      = '0;
          state_d     = ST_MUL;
        end
      end
      ST_MUL: begin
        ctrl_o.mul_en = 1'b1;
        state_d       = ST_ACC;
      end
      ST_ACC: begin
        ctrl_o.acc_en = 1'b1;
        if (step_q == LAST_STEP) begin
          state_d = ST_OUT;
        end else begin
          step_d  = step_q + 1'b1;
          state_d = ST_MUL;
        end
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

/* hdl/imu_nominal_state_integrator_core.sv */
// ----------------------------------------------------------------------------
// imu_nominal_state_integrator_core: first-order strapdown integrator
// Bias removal, quaternion rate, rotation of specific force, gravity and
// position / velocity update on one shared 33x33 multiplier.
// ----------------------------------------------------------------------------
//  channel  | signals                          | dir | moves
//  ---------+----------------------------------+-----+---------------------
//  in       | in_valid_i/in_ready_o/in_data_i  | in  | one IMU sample
//  out      | out_valid_o/out_ready_i/out_data_o| out | updated state
//  cfg      | cfg_valid_i/cfg_ready_o/idx/data | in  | register write
//
// From acceptance to result valid, one request runs 48 multiply/accumulate
// steps on the shared multiplier, each a multiply state then an accumulate state.
// Result held until taken, then the sequencer returns to idle.
// Not ready for a new request until the result has been taken.
// Reset restores the register defaults, the identity attitude and zero position and velocity.
// ----------------------------------------------------------------------------
module imu_nominal_state_integrator_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  imuni_pkg::imu_in_t                    in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output imuni_pkg::imu_out_t                   out_data_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [imuni_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [imuni_pkg::DATA_W-1:0]          cfg_data_i
);
  import imuni_pkg::*;

  seq_ctrl_t ctrl;
  uop_t      uop;

  logic        [DATA_W-1:0] step_time_q;
  logic signed [DATA_W-1:0] gravity_z_q;
  logic signed [DATA_W-1:0] gyro_bias_q [3];
  logic signed [DATA_W-1:0] accel_bias_q [3];

  logic signed [DATA_W-1:0] quat_q [4];
  logic signed [DATA_W-1:0] pos_q [3];
  logic signed [DATA_W-1:0] vel_q [3];

  logic signed [DATA_W-1:0] w_q [3];
  logic signed [DATA_W-1:0] a_q [3];
  logic signed [S_W-1:0]    s_q [4];
  logic signed [PP_W-1:0]   pp_q [9];
  logic signed [DATA_W-1:0] f_q [3];
  logic        [DATA_W-1:0] dt2_q;
  logic signed [DATA_W-1:0] r [9];

  src_e                   src_sel [2];
  logic [3:0]             src_idx [2];
  logic signed [OP_W-1:0] src_val [2];
  logic signed [OP_W-1:0] op_a, op_b;
  logic signed [PROD_W-1:0] prod_q, prod_sh;
  logic signed [ACC_W-1:0]  acc_q, acc_d, init_val;

  imuni_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctrl_o      (ctrl)
  );

  assign uop         = ucode(ctrl.step);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_time_q     <= STEP_TIME_RST;
      gravity_z_q     <= GRAVITY_RST;
      gyro_bias_q[0]  <= '0;
      gyro_bias_q[1]  <= '0;
      gyro_bias_q[2]  <= '0;
      accel_bias_q[0] <= '0;
      accel_bias_q[1] <= '0;
      accel_bias_q[2] <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_STEP_TIME:    step_time_q     <= cfg_data_i;
        REG_GRAVITY_Z:    gravity_z_q     <= cfg_data_i;
        REG_GYRO_BIAS_X:  gyro_bias_q[0]  <= cfg_data_i;
        REG_GYRO_BIAS_Y:  gyro_bias_q[1]  <= cfg_data_i;
        REG_GYRO_BIAS_Z:  gyro_bias_q[2]  <= cfg_data_i;
        REG_ACCEL_BIAS_X: accel_bias_q[0] <= cfg_data_i;
        REG_ACCEL_BIAS_Y: accel_bias_q[1] <= cfg_data_i;
        REG_ACCEL_BIAS_Z: accel_bias_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // rotation matrix of the held quaternion, built from the stored products
  // xx yy zz xy xz yz wx wy wz
  always_comb begin
    r[0] = sat32(ONE_Q30 - ((64'(pp_q[1]) + 64'(pp_q[2])) <<< 1));
    r[1] = sat32((64'(pp_q[3]) - 64'(pp_q[8])) <<< 1);
    r[2] = sat32((64'(pp_q[4]) + 64'(pp_q[7])) <<< 1);
    r[3] = sat32((64'(pp_q[3]) + 64'(pp_q[8])) <<< 1);
    r[4] = sat32(ONE_Q30 - ((64'(pp_q[0]) + 64'(pp_q[2])) <<< 1));
    r[5] = sat32((64'(pp_q[5]) - 64'(pp_q[6])) <<< 1);
    r[6] = sat32((64'(pp_q[4]) - 64'(pp_q[7])) <<< 1);
    r[7] = sat32((64'(pp_q[5]) + 64'(pp_q[6])) <<< 1);
    r[8] = sat32(ONE_Q30 - ((64'(pp_q[0]) + 64'(pp_q[1])) <<< 1));
  end

  // operand selection
  always_comb begin
    src_sel[0] = uop.a_src;
    src_idx[0] = uop.a_idx;
    src_sel[1] = uop.b_src;
    src_idx[1] = uop.b_idx;
    for (int p = 0; p < 2; p++) begin
      unique case (src_sel[p])
        SRC_W:   src_val[p] = OP_W'(w_q[src_idx[p][1:0]]);
        SRC_A:   src_val[p] = OP_W'(a_q[src_idx[p][1:0]]);
        SRC_Q:   src_val[p] = OP_W'(quat_q[src_idx[p][1:0]]);
        SRC_R:   src_val[p] = OP_W'(r[src_idx[p]]);
        SRC_DT:  src_val[p] = {1'b0, step_time_q};
        SRC_DT2: src_val[p] = {1'b0, dt2_q};
        SRC_SLO: src_val[p] = {1'b0, s_q[src_idx[p][1:0]][DATA_W-1:0]};
        SRC_SHI: src_val[p] = OP_W'(signed'(s_q[src_idx[p][1:0]][S_W-1:DATA_W]));
        SRC_V:   src_val[p] = OP_W'(vel_q[src_idx[p][1:0]]);
        SRC_F:   src_val[p] = OP_W'(f_q[src_idx[p][1:0]]);
        default: src_val[p] = '0;
      endcase
    end
    op_a = uop.a_neg ? -src_val[0] : src_val[0];
    op_b = src_val[1];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.mul_en) begin
      prod_q <= op_a * op_b;
    end
  end

  always_comb begin
    unique case (uop.shift)
      SH_0:    prod_sh = prod_q;
      SH_16:   prod_sh = prod_q >>> 16;
      SH_30:   prod_sh = prod_q >>> 30;
      SH_32:   prod_sh = prod_q >>> 32;
      SH_33:   prod_sh = prod_q >>> 33;
      default: prod_sh = prod_q;
    endcase
    unique case (uop.init)
      INIT_ZERO: init_val = '0;
      INIT_GRAV: init_val = ACC_W'(gravity_z_q);
      INIT_POS:  init_val = ACC_W'(pos_q[uop.idx[1:0]]);
      INIT_VEL:  init_val = ACC_W'(vel_q[uop.idx[1:0]]);
      default:   init_val = '0;
    endcase
    acc_d = (uop.first ? init_val : acc_q) + signed'(prod_sh[ACC_W-1:0]);
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (ctrl.load) begin
      w_q[0] <= sat32(64'(in_data_i.gyro_x) - 64'(gyro_bias_q[0]));
      w_q[1] <= sat32(64'(in_data_i.gyro_y) - 64'(gyro_bias_q[1]));
      w_q[2] <= sat32(64'(in_data_i.gyro_z) - 64'(gyro_bias_q[2]));
      a_q[0] <= sat32(64'(in_data_i.accel_x) - 64'(accel_bias_q[0]));
      a_q[1] <= sat32(64'(in_data_i.accel_y) - 64'(accel_bias_q[1]));
      a_q[2] <= sat32(64'(in_data_i.accel_z) - 64'(accel_bias_q[2]));
    end
    if (ctrl.acc_en) begin
      acc_q <= acc_d;
      unique case (uop.wr)
        WR_S:    s_q[uop.idx[1:0]] <= acc_d[S_W-1:0];
        WR_PP:   pp_q[uop.idx]     <= acc_d[PP_W-1:0];
        WR_F:    f_q[uop.idx[1:0]] <= sat32(64'(acc_d));
        WR_DT2:  dt2_q             <= acc_d[DATA_W-1:0];
        default: ;
      endcase
    end
  end

  // navigation state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quat_q[0] <= QUAT_ONE;
      quat_q[1] <= '0;
      quat_q[2] <= '0;
      quat_q[3] <= '0;
      pos_q[0]  <= '0;
      pos_q[1]  <= '0;
      pos_q[2]  <= '0;
      vel_q[0]  <= '0;
      vel_q[1]  <= '0;
      vel_q[2]  <= '0;
    end else if (ctrl.acc_en) begin
      unique case (uop.wr)
        WR_QUAT: quat_q[uop.idx[1:0]] <=
                   sat32(64'(quat_q[uop.idx[1:0]]) + 64'(acc_d >>> 1));
        WR_POS:  pos_q[uop.idx[1:0]] <= sat32(64'(acc_d));
        WR_VEL:  vel_q[uop.idx[1:0]] <= sat32(64'(acc_d));
        default: ;
      endcase
    end
  end

  always_comb begin
    out_data_o.quat_w = quat_q[0];
    out_data_o.quat_x = quat_q[1];
    out_data_o.quat_y = quat_q[2];
    out_data_o.quat_z = quat_q[3];
    out_data_o.pos_x  = pos_q[0];
    out_data_o.pos_y  = pos_q[1];
    out_data_o.pos_z  = pos_q[2];
    out_data_o.vel_x  = vel_q[0];
    out_data_o.vel_y  = vel_q[1];
    out_data_o.vel_z  = vel_q[2];
  end

`ifndef SYNTHESIS
  a_ready_xor_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while a result is pending");

  a_accept_clears_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !out_valid_o)
    else $error("result shown right after a request");

  a_no_write_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.acc_en || ctrl.mul_en) |-> (!in_ready_o && !out_valid_o))
    else $error("datapath active outside of a request");
`endif

endmodule
